>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, quiet while reset is held
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define ASSERT_NXT_ALL(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ilsu_pkg.sv
package ilsu_pkg;

  // field widths
  localparam int TIME_W  = 48;
  localparam int DUR_W   = 32;
  localparam int CNT_W   = 32;
  localparam int TOTAL_W = 48;
  localparam int FUNC_W  = 2;

  // event kinds
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXPIRE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // interval length after reset, in microseconds
  localparam logic [DUR_W-1:0] INTERVAL_RESET = 32'd60000000;

  // serial divider: one quotient bit per step
  localparam int DIV_STEPS = TOTAL_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

  // one accepted request
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TIME_W-1:0] now_time;
    logic [DUR_W-1:0]  sample_duration;
  } item_t;

  // previous interval as held by the statistics core
  typedef struct packed {
    logic               open;
    logic [TIME_W-1:0]  start;
    logic [CNT_W-1:0]   count;
    logic [DUR_W-1:0]   min;
    logic [DUR_W-1:0]   max;
    logic [TOTAL_W-1:0] total;
  } prev_stats_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/ilsu_div.sv
module ilsu_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ilsu_pkg::TOTAL_W-1:0]    dividend,
  input  logic [ilsu_pkg::CNT_W-1:0]      divisor,
  output logic [ilsu_pkg::DUR_W-1:0]      quotient,
  output ilsu_pkg::div_status_t           status
);

  logic [ilsu_pkg::TOTAL_W-1:0] quo;
  logic [ilsu_pkg::CNT_W-1:0]   rem;
  logic [ilsu_pkg::CNT_W-1:0]   dsr;
  logic [ilsu_pkg::STEP_W-1:0]  step;
  logic                         busy;
  logic                         done;

  logic [ilsu_pkg::CNT_W:0]     rem_sh;
  logic [ilsu_pkg::CNT_W:0]     diff;
  logic                         ge;

  // shared subtract and compare for one restoring step
  always_comb begin
    rem_sh = {rem, quo[ilsu_pkg::TOTAL_W-1]};
    diff   = rem_sh - {1'b0, dsr};
    ge     = (rem_sh >= {1'b0, dsr});
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == ilsu_pkg::LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  // datapath: one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[ilsu_pkg::TOTAL_W-2:0], ge};
      rem <= ge ? diff[ilsu_pkg::CNT_W-1:0] : rem_sh[ilsu_pkg::CNT_W-1:0];
    end
  end

  // zero count gives zero, oversize quotient clamps
  always_comb begin
    if (dsr == '0) begin
      quotient = '0;
    end else if (quo[ilsu_pkg::TOTAL_W-1:ilsu_pkg::DUR_W] != '0) begin
      quotient = '1;
    end else begin
      quotient = quo[ilsu_pkg::DUR_W-1:0];
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

>>> rtl/ilsu_stats.sv
module ilsu_stats (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ilsu_pkg::DUR_W-1:0]    cfg_wdata,
  input  logic                          upd,
  input  ilsu_pkg::item_t               item,
  output logic                          report,
  output logic                          no_interval_error,
  output ilsu_pkg::prev_stats_t         prev
);

  logic [ilsu_pkg::DUR_W-1:0]   interval_length;

  logic                         cur_open;
  logic [ilsu_pkg::TIME_W-1:0]  cur_start;
  logic [ilsu_pkg::CNT_W-1:0]   cur_count;
  logic [ilsu_pkg::DUR_W-1:0]   cur_min;
  logic [ilsu_pkg::DUR_W-1:0]   cur_max;
  logic [ilsu_pkg::TOTAL_W-1:0] cur_total;

  logic [ilsu_pkg::TIME_W-1:0]  elapsed;
  logic                         closes;
  logic                         fresh;
  logic [ilsu_pkg::CNT_W-1:0]   base_count;
  logic [ilsu_pkg::DUR_W-1:0]   base_min;
  logic [ilsu_pkg::DUR_W-1:0]   base_max;
  logic [ilsu_pkg::TOTAL_W-1:0] base_total;
  logic [ilsu_pkg::TOTAL_W:0]   sum;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_length <= ilsu_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      interval_length <= cfg_wdata;
    end
  end

  // elapsed time modulo the time width, and the base an added sample lands on
  always_comb begin
    elapsed = item.now_time - cur_start;
    closes  = elapsed > {{(ilsu_pkg::TIME_W-ilsu_pkg::DUR_W){1'b0}}, interval_length};
    fresh   = !cur_open || closes;
    if (fresh) begin
      base_count = '0;
      base_min   = '1;
      base_max   = '0;
      base_total = '0;
    end else begin
      base_count = cur_count;
      base_min   = cur_min;
      base_max   = cur_max;
      base_total = cur_total;
    end
    sum = {1'b0, base_total} +
          {{(ilsu_pkg::TOTAL_W+1-ilsu_pkg::DUR_W){1'b0}}, item.sample_duration};
  end

  // interval state update, one request per strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_open          <= 1'b0;
      cur_start         <= '0;
      cur_count         <= '0;
      cur_min           <= '1;
      cur_max           <= '0;
      cur_total         <= '0;
      prev              <= '0;
      report            <= 1'b0;
      no_interval_error <= 1'b0;
    end else if (upd) begin
      report            <= 1'b0;
      no_interval_error <= 1'b0;
      case (item.func)
        ilsu_pkg::FUNC_ADD: begin
          if (cur_open && closes) begin
            prev.open  <= 1'b1;
            prev.start <= cur_start;
            prev.count <= cur_count;
            prev.min   <= cur_min;
            prev.max   <= cur_max;
            prev.total <= cur_total;
            report     <= 1'b1;
          end
          if (fresh) begin
            cur_start <= item.now_time;
          end
          cur_open  <= 1'b1;
          cur_count <= (base_count == '1) ? base_count : base_count + 1'b1;
          cur_min   <= (item.sample_duration < base_min) ? item.sample_duration : base_min;
          cur_max   <= (item.sample_duration > base_max) ? item.sample_duration : base_max;
          cur_total <= sum[ilsu_pkg::TOTAL_W] ? '1 : sum[ilsu_pkg::TOTAL_W-1:0];
        end
        ilsu_pkg::FUNC_EXPIRE: begin
          if (!cur_open) begin
            no_interval_error <= 1'b1;
          end else begin
            prev.open  <= 1'b1;
            prev.start <= cur_start;
            prev.count <= cur_count;
            prev.min   <= cur_min;
            prev.max   <= cur_max;
            prev.total <= cur_total;
            cur_open   <= 1'b0;
            cur_start  <= '0;
            cur_count  <= '0;
            cur_min    <= '1;
            cur_max    <= '0;
            cur_total  <= '0;
          end
        end
        ilsu_pkg::FUNC_CLEAR: begin
          cur_open  <= 1'b0;
          cur_start <= '0;
          cur_count <= '0;
          cur_min   <= '1;
          cur_max   <= '0;
          cur_total <= '0;
          prev      <= '0;
        end
        default: begin
          // unused code leaves the intervals alone
        end
      endcase
    end
  end

endmodule

>>> rtl/interval_latency_statistics_unit.sv
// channel   direction  tdata (low bit first)                      tuser
// s_        in         now_time[47:0] sample_duration[79:48]      func[1:0]
// m_        out        report no_interval_error prev_start        prev_valid
//                      prev_count prev_min prev_max prev_total
//                      prev_mean, zero pad to 232 bits
// cfg_      in         cfg_wdata = interval_length, written when cfg_we is high
//
// a request goes from acceptance to result through the interval update, the
// load of the divider, 48 restoring divider steps for the mean, the divider
// done flag and the load of the output register.
// a new request is not taken before the last one has reached the output register.
// s_tready is high only while the sequencer is idle; a result waiting on
// m_tready stalls the next request at its final cycle, not at acceptance.
// rst is synchronous and active high and empties both intervals.
module interval_latency_statistics_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // now_time, sample_duration
  input  logic [1:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [231:0] m_tdata,   // report, no_interval_error, prev_start, prev_count,
                                  // prev_min, prev_max, prev_total, prev_mean, pad
  output logic [0:0]   m_tuser,   // prev_valid
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_START  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0]                   state;
  logic [2:0]                   state_next;
  ilsu_pkg::item_t              item;
  logic                         report;
  logic                         no_interval_error;
  ilsu_pkg::prev_stats_t        prev;
  logic [ilsu_pkg::DUR_W-1:0]   mean;
  ilsu_pkg::div_status_t        div_status;
  logic                         accept;
  logic                         out_free;
  logic                         load_out;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign load_out = (state == S_HOLD) && out_free;

  // latch the request
  always_ff @(posedge clk) begin
    if (accept) begin
      item.func            <= s_tuser;
      item.now_time        <= s_tdata[47:0];
      item.sample_duration <= s_tdata[79:48];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_UPDATE;
      S_UPDATE: state_next = S_START;
      S_START:  state_next = S_DIV;
      S_DIV:    if (div_status.done) state_next = S_HOLD;
      S_HOLD:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // interval statistics
  ilsu_stats u_stats (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .upd               (state == S_UPDATE),
    .item              (item),
    .report            (report),
    .no_interval_error (no_interval_error),
    .prev              (prev)
  );

  // mean of the previous interval
  ilsu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_START),
    .dividend (prev.total),
    .divisor  (prev.count),
    .quotient (mean),
    .status   (div_status)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {6'b0, mean, prev.total, prev.max, prev.min, prev.count, prev.start,
                  no_interval_error, report};
      m_tuser <= prev.open;
    end
  end

endmodule

>>> rtl/ilsu_checker.sv
`include "assert_macros.svh"

module ilsu_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [231:0] m_tdata,
  input logic [0:0]   m_tuser
);

  // a taken request keeps the input closed for at least the next cycle
  `ASSERT_NXT(busy_after_request, s_tvalid && s_tready, !s_tready)

  // a stalled result holds
  `ASSERT_NXT(result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // with no previous interval every statistic reads zero
  `ASSERT_IMP(empty_prev_zero, m_tvalid && !m_tuser[0], m_tdata[225:2] == '0)

  // a report always leaves a previous interval and never comes with an error
  `ASSERT_IMP(report_consistent, m_tvalid && m_tdata[0], m_tuser[0] && !m_tdata[1])

  // reset drops any pending result
  `ASSERT_NXT_ALL(reset_clears_output, rst, !m_tvalid)

endmodule

bind interval_latency_statistics_unit ilsu_checker u_ilsu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
